### src/chba_pkg.sv
`default_nettype none
package chba_pkg;
  localparam int DefNumCells   = 256;
  localparam int DefNumSamples = 160;
  localparam int DefBinWidth   = 20;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_DEPOSIT = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOMATCH = 2'd1;
  localparam logic [1:0] ST_TIME    = 2'd2;
  localparam logic [1:0] ST_RANGE   = 2'd3;

  localparam logic REG_CELLS_IN_USE = 1'b0;
  localparam logic REG_WINDOW_START = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic capture;     // latch request fields
    logic load_cell;   // write cell tables
    logic scan_start;  // reset scan counter, issue first table read
    logic scan_next;   // advance scan counter
    logic div_start;   // start time binning
    logic sum_read;    // issue sum memory read
    logic sum_write;   // write updated sum
    logic clr_start;   // reset clear counter
    logic clr_step;    // write zero, advance clear counter
    logic set_result;  // latch result from datapath
  } chba_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] command;
    logic       index_bad;
    logic       hit;        // compare of current cell on registered table data
    logic       scan_last;  // current cell is last to test
    logic       scan_empty; // no cells in use
    logic       time_bad;
    logic       div_done;
    logic       clr_last;
  } chba_sts_t;
endpackage
`default_nettype wire

### src/chba_ctrl.sv
`default_nettype none
module chba_ctrl
  import chba_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire chba_sts_t sts,
  output chba_cmd_t      cmd
);
  typedef enum logic [10:0] {
    S_INIT  = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_DEC   = 11'b00000000100,
    S_SCAN0 = 11'b00000001000,
    S_SCAN  = 11'b00000010000,
    S_DIV   = 11'b00000100000,
    S_RD    = 11'b00001000000,
    S_WR    = 11'b00010000000,
    S_CLR   = 11'b00100000000,
    S_OUT   = 11'b01000000000,
    S_MISS  = 11'b10000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_INIT;
    else state <= state_next;
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  // sequencing
  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_INIT: begin
        // zero every sum once after reset, no result
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.index_bad) begin
          cmd.set_result = 1'b1;
          state_next = S_OUT;
        end else begin
          unique case (sts.command)
            CMD_LOAD: begin
              cmd.load_cell = 1'b1;
              cmd.set_result = 1'b1;
              state_next = S_OUT;
            end
            CMD_READ: begin
              cmd.sum_read = 1'b1;
              state_next = S_RD;
            end
            CMD_CLEAR: begin
              cmd.clr_start = 1'b1;
              state_next = S_CLR;
            end
            default: begin
              if (sts.scan_empty) state_next = S_MISS;
              else begin
                cmd.scan_start = 1'b1;
                state_next = S_SCAN0;
              end
            end
          endcase
        end
      end
      S_SCAN0: begin
        // table read in flight; compare registers next cycle
        cmd.scan_next = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (sts.hit) begin
          cmd.div_start = 1'b1;
          state_next = S_DIV;
        end else if (sts.scan_last) state_next = S_MISS;
        else cmd.scan_next = 1'b1;
      end
      S_DIV: begin
        if (sts.time_bad) begin
          cmd.set_result = 1'b1;
          state_next = S_OUT;
        end else if (sts.div_done) begin
          cmd.sum_read = 1'b1;
          state_next = S_RD;
        end
      end
      S_RD: begin
        if (sts.command == CMD_DEPOSIT) begin
          state_next = S_WR;
        end else begin
          cmd.set_result = 1'b1;
          state_next = S_OUT;
        end
      end
      S_WR: begin
        cmd.sum_write = 1'b1;
        cmd.set_result = 1'b1;
        state_next = S_OUT;
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          cmd.set_result = 1'b1;
          state_next = S_OUT;
        end
      end
      S_MISS: begin
        cmd.set_result = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### src/chba_datapath.sv
`default_nettype none
module chba_datapath
  import chba_pkg::*;
#(
  parameter int NUM_CELLS   = DefNumCells,
  parameter int NUM_SAMPLES = DefNumSamples,
  parameter int BIN_WIDTH   = DefBinWidth
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire chba_cmd_t          cmd,
  output chba_sts_t               sts,
  input  wire logic               cfg_write,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic [1:0]         command,
  input  wire logic [7:0]         cell_index,
  input  wire logic [7:0]         sample_index,
  input  wire logic signed [15:0] eta,
  input  wire logic signed [15:0] phi,
  input  wire logic [11:0]        radius,
  input  wire logic [14:0]        eta_half_width,
  input  wire logic [14:0]        phi_half_width,
  input  wire logic [11:0]        radius_min,
  input  wire logic [11:0]        radius_max,
  input  wire logic signed [15:0] hit_time,
  input  wire logic [23:0]        energy,
  output logic [1:0]              status,
  output logic [7:0]              matched_cell,
  output logic [7:0]              time_bin,
  output logic [31:0]             sample_sum
);
  localparam int CW    = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int SW    = $clog2(NUM_SAMPLES);
  localparam int DEPTH = NUM_CELLS * NUM_SAMPLES;
  localparam int AW    = $clog2(DEPTH);
  localparam int LIMIT = (NUM_SAMPLES - 1) * BIN_WIDTH;
  localparam int UW    = 9; // cells_in_use width
  localparam int NW    = (CW + 1 > UW) ? CW + 1 : UW;

  // configuration registers
  logic [8:0]         cells_in_use;
  logic signed [15:0] window_start;
  always_ff @(posedge clk) begin
    if (rst) begin
      cells_in_use <= '0;
      window_start <= -16'sd640;
    end else if (cfg_write) begin
      if (cfg_index == REG_CELLS_IN_USE) cells_in_use <= cfg_data[8:0];
      else window_start <= cfg_data;
    end
  end

  // captured request
  logic [1:0]         r_cmd;
  logic [7:0]         r_ci, r_si;
  logic signed [15:0] r_eta, r_phi, r_time;
  logic [11:0]        r_rad, r_rmin, r_rmax;
  logic [14:0]        r_de, r_dp;
  logic [23:0]        r_e;
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      r_cmd <= command; r_ci <= cell_index; r_si <= sample_index;
      r_eta <= eta; r_phi <= phi; r_time <= hit_time; r_rad <= radius;
      r_rmin <= radius_min; r_rmax <= radius_max;
      r_de <= eta_half_width; r_dp <= phi_half_width; r_e <= energy;
    end
  end

  // cell count clipped to table size
  logic [NW-1:0] n_cells;
  assign n_cells = ({{(NW-UW){1'b0}}, cells_in_use} > NW'(NUM_CELLS)) ?
                   NW'(NUM_CELLS) : {{(NW-UW){1'b0}}, cells_in_use};

  // cell tables
  logic [61:0] angle_mem [NUM_CELLS];
  logic [23:0] radii_mem [NUM_CELLS];
  logic [61:0] angle_q;
  logic [23:0] radii_q;
  logic [CW:0] scan_addr;   // address issued to tables
  logic [CW:0] cmp_cell;    // cell whose data is in angle_q
  always_ff @(posedge clk) begin
    if (cmd.load_cell) begin
      angle_mem[r_ci[CW-1:0]] <= {r_dp, r_de, r_phi, r_eta};
      radii_mem[r_ci[CW-1:0]] <= {r_rmax, r_rmin};
    end
    angle_q <= angle_mem[scan_addr[CW-1:0]];
    radii_q <= radii_mem[scan_addr[CW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_addr <= '0;
      cmp_cell  <= '0;
    end else if (cmd.scan_next) begin
      scan_addr <= scan_addr + 1'b1;
      cmp_cell  <= scan_addr;
    end
  end

  // window compare on registered table data, signed 18-bit
  logic signed [16:0] ce, cp, de, dp, he, hp;
  logic               in_win;
  always_comb begin
    ce = {angle_q[15], angle_q[15:0]};
    cp = {angle_q[31], angle_q[31:16]};
    de = {2'b00, angle_q[46:32]};
    dp = {2'b00, angle_q[61:47]};
    he = {r_eta[15], r_eta};
    hp = {r_phi[15], r_phi};
    in_win = (r_rad < radii_q[23:12]) && (r_rad >= radii_q[11:0]) &&
             ($signed({he[16], he}) < ($signed({ce[16], ce}) + $signed({de[16], de}))) &&
             ($signed({he[16], he}) >= ($signed({ce[16], ce}) - $signed({de[16], de}))) &&
             ($signed({hp[16], hp}) < ($signed({cp[16], cp}) + $signed({dp[16], dp}))) &&
             ($signed({hp[16], hp}) >= ($signed({cp[16], cp}) - $signed({dp[16], dp})));
  end

  // time offset; bin by reciprocal multiply, exact for offsets below 2^16
  logic signed [16:0] d_time;
  assign d_time = {r_time[15], r_time} - {window_start[15], window_start};
  localparam int     QS    = 16 + $clog2(BIN_WIDTH);
  localparam longint RECIP = ((longint'(1) << QS) + longint'(BIN_WIDTH) - 1) /
                             longint'(BIN_WIDTH);
  localparam int     RW    = QS + 1;
  logic [RW+15:0] q_prod;
  assign q_prod = {{RW{1'b0}}, d_time[15:0]} * (RW+16)'(RECIP);
  logic [SW-1:0] bin;
  logic          dv_done;
  always_ff @(posedge clk) begin
    if (rst) dv_done <= 1'b0;
    else dv_done <= cmd.div_start;
    if (cmd.div_start) bin <= SW'(q_prod >> QS);
  end
  logic div_started;
  always_ff @(posedge clk) begin
    if (rst) div_started <= 1'b0;
    else if (cmd.div_start) div_started <= 1'b1;
    else if (cmd.capture) div_started <= 1'b0;
  end
  logic time_bad;
  assign time_bad = d_time[16] || (int'(d_time) >= LIMIT);

  // energy sum memory
  logic [31:0] sum_mem [DEPTH];
  logic [31:0] sum_q;
  logic [AW-1:0] sum_addr, clr_addr;
  logic [AW-1:0] base;
  logic [AW-1:0] mul_in;
  logic [SW-1:0] sidx;
  logic [CW-1:0] cidx;
  always_comb begin
    if (r_cmd == CMD_READ) begin
      cidx = r_ci[CW-1:0];
      sidx = r_si[SW-1:0];
    end else begin
      cidx = cmp_cell[CW-1:0];
      sidx = bin;
    end
    mul_in = AW'(cidx);
    base = AW'(mul_in * AW'(NUM_SAMPLES));
  end
  always_ff @(posedge clk) begin
    if (cmd.sum_read) sum_addr <= base + AW'(sidx);
  end
  logic [32:0] sum_add;
  logic [31:0] sum_new;
  assign sum_add = {1'b0, sum_q} + {9'd0, r_e};
  assign sum_new = sum_add[32] ? 32'hFFFF_FFFF : sum_add[31:0];
  logic rd_pend;
  always_ff @(posedge clk) begin
    rd_pend <= cmd.sum_read;
    if (cmd.clr_step) sum_mem[clr_addr] <= '0;
    else if (cmd.sum_write) sum_mem[sum_addr] <= sum_new;
    if (rd_pend) sum_q <= sum_mem[sum_addr];
  end
  // clear counter, also walked once after reset
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_start) clr_addr <= '0;
    else if (cmd.clr_step) clr_addr <= clr_addr + 1'b1;
  end

  // status to controller
  logic index_bad;
  always_comb begin
    index_bad = 1'b0;
    if (r_cmd == CMD_LOAD || r_cmd == CMD_READ)
      index_bad = (int'(r_ci) >= NUM_CELLS);
    if (r_cmd == CMD_READ && (int'(r_si) >= NUM_SAMPLES)) index_bad = 1'b1;
  end
  assign sts.command    = r_cmd;
  assign sts.index_bad  = index_bad;
  assign sts.hit        = in_win;
  assign sts.scan_last  = (NW'(cmp_cell) + 1'b1) >= n_cells;
  assign sts.scan_empty = (n_cells == '0);
  assign sts.time_bad   = dv_done && time_bad;
  assign sts.div_done   = dv_done;
  assign sts.clr_last   = (clr_addr == AW'(DEPTH - 1));

  // result status
  logic [1:0] res_status;
  always_comb begin
    res_status = ST_DONE;
    if (index_bad) res_status = ST_RANGE;
    else if (r_cmd == CMD_DEPOSIT) begin
      if (!div_started) res_status = ST_NOMATCH;
      else if (time_bad) res_status = ST_TIME;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.set_result) begin
      status <= res_status;
      if (res_status == ST_DONE && r_cmd == CMD_DEPOSIT) begin
        matched_cell <= 8'(cmp_cell);
        time_bin     <= 8'(bin);
        sample_sum   <= sum_new;
      end else if (res_status == ST_DONE && r_cmd == CMD_READ) begin
        matched_cell <= '0;
        time_bin     <= '0;
        sample_sum   <= sum_mem[sum_addr];
      end else begin
        matched_cell <= '0;
        time_bin     <= '0;
        sample_sum   <= '0;
      end
    end
  end
endmodule
`default_nettype wire

### src/calorimeter_hit_binning_accumulator.sv
// Deposit: table scan, one cell per cycle, then a reciprocal bin multiply and
//   a sum read-modify-write. Clear: one sum zeroed per cycle.
// Throughput: one request at a time; the next is taken after the result leaves.
// Reset: synchronous; resets control registers, clears cells_in_use, sets
//   window_start to -640, then a clearing pass zeroes every sum with input held off.
//   Cell tables are undefined until loaded.
`default_nettype none
module calorimeter_hit_binning_accumulator
  import chba_pkg::*;
#(
  parameter int NUM_CELLS   = DefNumCells,
  parameter int NUM_SAMPLES = DefNumSamples,
  parameter int BIN_WIDTH   = DefBinWidth
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         command,
  input  wire logic [7:0]         cell_index,
  input  wire logic [7:0]         sample_index,
  input  wire logic signed [15:0] eta,
  input  wire logic signed [15:0] phi,
  input  wire logic [11:0]        radius,
  input  wire logic [14:0]        eta_half_width,
  input  wire logic [14:0]        phi_half_width,
  input  wire logic [11:0]        radius_min,
  input  wire logic [11:0]        radius_max,
  input  wire logic signed [15:0] hit_time,
  input  wire logic [23:0]        energy,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              status,
  output logic [7:0]              matched_cell,
  output logic [7:0]              time_bin,
  output logic [31:0]             sample_sum
);
  chba_cmd_t cmd;
  chba_sts_t sts;

  chba_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  chba_datapath #(
    .NUM_CELLS(NUM_CELLS), .NUM_SAMPLES(NUM_SAMPLES), .BIN_WIDTH(BIN_WIDTH)
  ) u_dp (
    .clk, .rst, .cmd, .sts, .cfg_write, .cfg_index, .cfg_data,
    .command, .cell_index, .sample_index, .eta, .phi, .radius,
    .eta_half_width, .phi_half_width, .radius_min, .radius_max,
    .hit_time, .energy, .status, .matched_cell, .time_bin, .sample_sum
  );
endmodule
`default_nettype wire
